[rtl/s2l_pkg.sv]
// shared types, constants and table builders for the srgb to cielab pipeline
`default_nettype none

package s2l_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic [6:0]        lightness;
        logic signed [7:0] a_star;
        logic signed [7:0] b_star;
    } pixel_out_t;

    localparam int unsigned GAMMA_DEPTH = 256;
    localparam int unsigned SEG_BITS    = 10;
    localparam int unsigned CBRT_DEPTH  = (1 << SEG_BITS) + 1;

    // matrix rows, x and z rows pre-scaled by 100 so the white point divide is integral
    localparam int unsigned KX_R  = 412400;
    localparam int unsigned KX_G  = 357600;
    localparam int unsigned KX_B  = 180400;
    localparam int unsigned X_RND = 475228;
    localparam int unsigned X_DIV = 950456;
    localparam int unsigned KY_R  = 2126;
    localparam int unsigned KY_G  = 7152;
    localparam int unsigned KY_B  = 722;
    localparam int unsigned Y_RND = 5000;
    localparam int unsigned Y_DIV = 10000;
    localparam int unsigned KZ_R  = 19300;
    localparam int unsigned KZ_G  = 119200;
    localparam int unsigned KZ_B  = 950200;
    localparam int unsigned Z_RND = 544377;
    localparam int unsigned Z_DIV = 1088754;

    // dark segment: (7787*t + 500) / 1000 via reciprocal, exact below 2**31
    localparam int unsigned   LIN_MUL   = 7787;
    localparam int unsigned   LIN_RND   = 500;
    localparam int unsigned   LIN_W     = 31;
    localparam logic [63:0]   LIN_MAGIC = 64'd2199023256;
    localparam int unsigned   LIN_SHIFT = 41;

    localparam int unsigned L_SCALE = 116;
    localparam int unsigned L_BIAS  = 16;
    localparam int unsigned L_MAX   = 100;
    localparam int unsigned A_SCALE = 500;
    localparam int unsigned B_SCALE = 200;

    function automatic logic [63:0] mul30(logic [63:0] a, logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    // largest q30 y with y**n <= x
    function automatic logic [63:0] root30(logic [63:0] x, int unsigned n);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        lo = 64'd0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            p = mid;
            for (int unsigned i = 1; i < n; i++) begin
                p = mul30(p, mid);
            end
            if (p <= x) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return lo;
    endfunction

    function automatic logic [63:0] to_frac(logic [63:0] v30, int unsigned f);
        return (v30 + (64'd1 << (29 - f))) >> (30 - f);
    endfunction

    function automatic logic [63:0] gamma_entry(int unsigned c, int unsigned f);
        logic [63:0] cc;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] v30;
        cc = 64'(c);
        if (cc * 64'd100000 > 64'd1031475) begin
            x   = (((cc * 64'd1000 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
            y   = root30(x, 5);
            v30 = mul30(mul30(x, x), mul30(y, y));
        end else begin
            v30 = (((cc * 64'd10) << 30) + 64'd16473) / 64'd32946;
        end
        return to_frac(v30, f);
    endfunction

    function automatic logic [63:0] cbrt_entry(int unsigned k, int unsigned f);
        return to_frac(root30(64'(k) << (30 - SEG_BITS), 3), f);
    endfunction

    function automatic logic [63:0] lab_thr(int unsigned f);
        return ((64'd8856 << f) + 64'd500000) / 64'd1000000;
    endfunction

    function automatic logic [63:0] lab_off(int unsigned f);
        return ((64'd16 << f) + 64'd58) / 64'd116;
    endfunction

endpackage

`default_nettype wire

[rtl/srgb_to_cielab_pixel.sv]
// top level: srgb pixel in, cielab d65 pixel out, fully pipelined
//
//  channel | ports                       | payload
//  --------+-----------------------------+----------------------------------
//  input   | s_valid, s_ready, s_data    | red, green, blue (8b unsigned)
//  output  | m_valid, m_ready, m_data    | lightness 7b, a_star/b_star 8b s
//
// one request accepted per clock while the output is not stalled; the white point
// divider resolves four quotient bits per stage
// aresetn (synchronous) clears only the valid bits; tables are constant logic
// each stage loads when empty or when the stage after it moves, so bubbles
// fill in under a stall and nothing is dropped or repeated
`default_nettype none

module srgb_to_cielab_pixel #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire s2l_pkg::pixel_in_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output s2l_pkg::pixel_out_t       m_data
);

    localparam int unsigned FRAC_W   = FRACTION_BITS;
    // widest numerator is the z row: 1088700 * 2**F plus rounding
    localparam int unsigned NUM_W    = FRAC_W + 21;
    // normalized values stay below two
    localparam int unsigned QUO_W    = FRAC_W + 1;
    localparam int unsigned DIV_STEP = 4;
    localparam int unsigned DIV_STG  = (QUO_W + DIV_STEP - 1) / DIV_STEP;
    // gamma, products, sums | divider | lab f (3) | scale, saturate (2)
    localparam int unsigned MAT_BASE = 0;
    localparam int unsigned DIV_BASE = 3;
    localparam int unsigned LF_BASE  = DIV_BASE + DIV_STG;
    localparam int unsigned LAB_BASE = LF_BASE + 3;
    localparam int unsigned STG_CNT  = LAB_BASE + 2;

    logic [STG_CNT-1:0] stage_en;

    s2l_ctrl #(
        .STG_CNT (STG_CNT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stage_en (stage_en)
    );

    logic [NUM_W-1:0] num_x, num_y, num_z;

    // linearize each byte, then x/y/z numerators scaled for the divide
    s2l_matrix #(
        .FRAC_W (FRAC_W),
        .NUM_W  (NUM_W)
    ) u_matrix (
        .aclk     (aclk),
        .stage_en (stage_en[MAT_BASE +: 3]),
        .pix      (s_data),
        .num_x    (num_x),
        .num_y    (num_y),
        .num_z    (num_z)
    );

    logic [QUO_W-1:0] t_x, t_y, t_z;

    // divide by the white point, rounded to nearest
    s2l_cdiv #(
        .NUM_W   (NUM_W),
        .QUO_W   (QUO_W),
        .DIVISOR (s2l_pkg::X_DIV),
        .STEP_W  (DIV_STEP),
        .NSTG    (DIV_STG)
    ) u_div_x (
        .aclk     (aclk),
        .stage_en (stage_en[DIV_BASE +: DIV_STG]),
        .num      (num_x),
        .quo      (t_x)
    );

    s2l_cdiv #(
        .NUM_W   (NUM_W),
        .QUO_W   (QUO_W),
        .DIVISOR (s2l_pkg::Y_DIV),
        .STEP_W  (DIV_STEP),
        .NSTG    (DIV_STG)
    ) u_div_y (
        .aclk     (aclk),
        .stage_en (stage_en[DIV_BASE +: DIV_STG]),
        .num      (num_y),
        .quo      (t_y)
    );

    s2l_cdiv #(
        .NUM_W   (NUM_W),
        .QUO_W   (QUO_W),
        .DIVISOR (s2l_pkg::Z_DIV),
        .STEP_W  (DIV_STEP),
        .NSTG    (DIV_STG)
    ) u_div_z (
        .aclk     (aclk),
        .stage_en (stage_en[DIV_BASE +: DIV_STG]),
        .num      (num_z),
        .quo      (t_z)
    );

    logic [FRAC_W:0] f_x, f_y, f_z;

    // one f() lane per axis, each with its own cube root rom
    s2l_labf #(
        .FRAC_W (FRAC_W)
    ) u_labf_x (
        .aclk     (aclk),
        .stage_en (stage_en[LF_BASE +: 3]),
        .t        (t_x),
        .f        (f_x)
    );

    s2l_labf #(
        .FRAC_W (FRAC_W)
    ) u_labf_y (
        .aclk     (aclk),
        .stage_en (stage_en[LF_BASE +: 3]),
        .t        (t_y),
        .f        (f_y)
    );

    s2l_labf #(
        .FRAC_W (FRAC_W)
    ) u_labf_z (
        .aclk     (aclk),
        .stage_en (stage_en[LF_BASE +: 3]),
        .t        (t_z),
        .f        (f_z)
    );

    // final stage register is the output register
    s2l_lab #(
        .FRAC_W (FRAC_W)
    ) u_lab (
        .aclk     (aclk),
        .stage_en (stage_en[LAB_BASE +: 2]),
        .fx       (f_x),
        .fy       (f_y),
        .fz       (f_z),
        .pix      (m_data)
    );

endmodule

`default_nettype wire

[rtl/s2l_ctrl.sv]
// valid chain and per-stage load enables of the pipeline
`default_nettype none

module s2l_ctrl #(
    parameter int unsigned STG_CNT = 13
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [STG_CNT-1:0]      stage_en
);

    logic [STG_CNT-1:0] valid_reg;
    logic [STG_CNT-1:0] valid_next;

    // a stage loads when it is empty or the stage after it moves
    always_comb begin
        stage_en[STG_CNT-1] = !valid_reg[STG_CNT-1] || m_ready;
        for (int k = STG_CNT - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_comb begin
        valid_next[0] = stage_en[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < STG_CNT; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[STG_CNT-1];

endmodule

`default_nettype wire

[rtl/s2l_matrix.sv]
// gamma table lookup and rgb to xyz matrix numerators
`default_nettype none

module s2l_matrix #(
    parameter int unsigned FRAC_W = 16,
    parameter int unsigned NUM_W  = 37
) (
    input  wire logic                aclk,
    input  wire logic [2:0]          stage_en,
    input  wire s2l_pkg::pixel_in_t  pix,
    output logic [NUM_W-1:0]         num_x,
    output logic [NUM_W-1:0]         num_y,
    output logic [NUM_W-1:0]         num_z
);

    logic [FRAC_W:0] gamma_lut [s2l_pkg::GAMMA_DEPTH];

    for (genvar c = 0; c < s2l_pkg::GAMMA_DEPTH; c++) begin : g_lut
        assign gamma_lut[c] = (FRAC_W+1)'(s2l_pkg::gamma_entry(c, FRAC_W));
    end

    logic [FRAC_W:0]  lin_r_reg, lin_g_reg, lin_b_reg;
    logic [NUM_W-1:0] prod_reg [9];
    logic [NUM_W-1:0] num_x_reg, num_y_reg, num_z_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            lin_r_reg <= gamma_lut[pix.red];
            lin_g_reg <= gamma_lut[pix.green];
            lin_b_reg <= gamma_lut[pix.blue];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            prod_reg[0] <= NUM_W'(s2l_pkg::KX_R) * NUM_W'(lin_r_reg);
            prod_reg[1] <= NUM_W'(s2l_pkg::KX_G) * NUM_W'(lin_g_reg);
            prod_reg[2] <= NUM_W'(s2l_pkg::KX_B) * NUM_W'(lin_b_reg);
            prod_reg[3] <= NUM_W'(s2l_pkg::KY_R) * NUM_W'(lin_r_reg);
            prod_reg[4] <= NUM_W'(s2l_pkg::KY_G) * NUM_W'(lin_g_reg);
            prod_reg[5] <= NUM_W'(s2l_pkg::KY_B) * NUM_W'(lin_b_reg);
            prod_reg[6] <= NUM_W'(s2l_pkg::KZ_R) * NUM_W'(lin_r_reg);
            prod_reg[7] <= NUM_W'(s2l_pkg::KZ_G) * NUM_W'(lin_g_reg);
            prod_reg[8] <= NUM_W'(s2l_pkg::KZ_B) * NUM_W'(lin_b_reg);
        end
    end

    // rounding offsets make the later floor divide a round to nearest
    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            num_x_reg <= prod_reg[0] + prod_reg[1] + prod_reg[2] + NUM_W'(s2l_pkg::X_RND);
            num_y_reg <= prod_reg[3] + prod_reg[4] + prod_reg[5] + NUM_W'(s2l_pkg::Y_RND);
            num_z_reg <= prod_reg[6] + prod_reg[7] + prod_reg[8] + NUM_W'(s2l_pkg::Z_RND);
        end
    end

    assign num_x = num_x_reg;
    assign num_y = num_y_reg;
    assign num_z = num_z_reg;

endmodule

`default_nettype wire

[rtl/s2l_cdiv.sv]
// pipelined restoring divide by a constant, STEP_W quotient bits per stage
`default_nettype none

module s2l_cdiv #(
    parameter int unsigned  NUM_W   = 37,
    parameter int unsigned  QUO_W   = 17,
    parameter longint unsigned DIVISOR = 950456,
    parameter int unsigned  STEP_W  = 4,
    parameter int unsigned  NSTG    = (QUO_W + STEP_W - 1) / STEP_W
) (
    input  wire logic              aclk,
    input  wire logic [NSTG-1:0]   stage_en,
    input  wire logic [NUM_W-1:0]  num,
    output logic [QUO_W-1:0]       quo
);

    localparam int unsigned REM_W = $clog2(DIVISOR);

    logic [REM_W-1:0] rem_reg [NSTG];
    logic [QUO_W-1:0] low_reg [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [REM_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [REM_W-1:0] rem_out;
        logic [QUO_W-1:0] low_out;

        if (s == 0) begin : g_first
            // upper numerator bits are already below the divisor
            assign rem_in = REM_W'(num >> QUO_W);
            assign low_in = QUO_W'(num);
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign low_in = low_reg[s-1];
        end

        // low word shifts numerator bits out the top and quotient bits in the bottom
        always_comb begin
            logic [REM_W:0]   r;
            logic [QUO_W-1:0] w;
            r = {1'b0, rem_in};
            w = low_in;
            for (int unsigned j = 0; j < STEP_W; j++) begin
                if (s * STEP_W + j < QUO_W) begin
                    r = {r[REM_W-1:0], w[QUO_W-1]};
                    w = {w[QUO_W-2:0], 1'b0};
                    if (r >= (REM_W+1)'(DIVISOR)) begin
                        r    = r - (REM_W+1)'(DIVISOR);
                        w[0] = 1'b1;
                    end
                end
            end
            rem_out = r[REM_W-1:0];
            low_out = w;
        end

        always_ff @(posedge aclk) begin
            if (stage_en[s]) begin
                rem_reg[s] <= rem_out;
                low_reg[s] <= low_out;
            end
        end
    end

    assign quo = low_reg[NSTG-1];

endmodule

`default_nettype wire

[rtl/s2l_labf.sv]
// lab f(): linear dark segment or interpolated cube root from a rom
`default_nettype none

module s2l_labf #(
    parameter int unsigned FRAC_W = 16
) (
    input  wire logic            aclk,
    input  wire logic [2:0]      stage_en,
    input  wire logic [FRAC_W:0] t,
    output logic [FRAC_W:0]      f
);

    localparam int unsigned SH     = FRAC_W - s2l_pkg::SEG_BITS;
    localparam int unsigned FRW    = (SH > 0) ? SH : 1;
    localparam int unsigned ADDR_W = $clog2(s2l_pkg::CBRT_DEPTH);
    localparam int unsigned LW     = s2l_pkg::LIN_W;
    localparam logic [FRAC_W:0] ONE = (FRAC_W+1)'(1) << FRAC_W;
    localparam logic [FRAC_W:0] THR = (FRAC_W+1)'(s2l_pkg::lab_thr(FRAC_W));
    localparam logic [FRAC_W:0] OFF = (FRAC_W+1)'(s2l_pkg::lab_off(FRAC_W));
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(s2l_pkg::CBRT_DEPTH - 1);

    logic [FRAC_W:0] cbrt_rom [s2l_pkg::CBRT_DEPTH];

    for (genvar k = 0; k < s2l_pkg::CBRT_DEPTH; k++) begin : g_rom
        assign cbrt_rom[k] = (FRAC_W+1)'(s2l_pkg::cbrt_entry(k, FRAC_W));
    end

    logic [FRAC_W:0]   tc;
    logic [ADDR_W-1:0] addr_lo, addr_hi;
    logic [FRW-1:0]    frac_c;
    logic [LW-1:0]     lin_n_c;

    assign tc      = (t > ONE) ? ONE : t;
    assign addr_lo = ADDR_W'(tc >> SH);
    assign addr_hi = (addr_lo == LAST) ? LAST : addr_lo + ADDR_W'(1);
    assign frac_c  = (SH > 0) ? FRW'(tc) : '0;
    // only meaningful on the dark segment, where it stays below 2**31
    assign lin_n_c = LW'(tc) * LW'(s2l_pkg::LIN_MUL) + LW'(s2l_pkg::LIN_RND);

    logic [FRAC_W:0] lo_reg, hi_reg, lo_d_reg, interp_reg, lin_q_reg, f_reg;
    logic [FRW-1:0]  frac_reg;
    logic [LW-1:0]   lin_n_reg;
    logic            is_lin_reg, is_lin_d_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            lo_reg     <= cbrt_rom[addr_lo];
            hi_reg     <= cbrt_rom[addr_hi];
            frac_reg   <= frac_c;
            lin_n_reg  <= lin_n_c;
            is_lin_reg <= (tc <= THR);
        end
    end

    logic [FRAC_W+FRW:0] slope_prod;
    logic [63:0]         lin_prod;

    assign slope_prod = (FRAC_W+FRW+1)'(hi_reg - lo_reg) * (FRAC_W+FRW+1)'(frac_reg);
    assign lin_prod   = 64'(lin_n_reg) * s2l_pkg::LIN_MAGIC;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            interp_reg   <= (FRAC_W+1)'(slope_prod >> SH);
            lin_q_reg    <= (FRAC_W+1)'(lin_prod >> s2l_pkg::LIN_SHIFT);
            lo_d_reg     <= lo_reg;
            is_lin_d_reg <= is_lin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            f_reg <= is_lin_d_reg ? lin_q_reg + OFF : lo_d_reg + interp_reg;
        end
    end

    assign f = f_reg;

endmodule

`default_nettype wire

[rtl/s2l_lab.sv]
// l, a, b scaling, truncation toward zero and saturation into the output register
`default_nettype none

module s2l_lab #(
    parameter int unsigned FRAC_W = 16
) (
    input  wire logic             aclk,
    input  wire logic [1:0]       stage_en,
    input  wire logic [FRAC_W:0]  fx,
    input  wire logic [FRAC_W:0]  fy,
    input  wire logic [FRAC_W:0]  fz,
    output s2l_pkg::pixel_out_t   pix
);

    localparam int unsigned L_W = FRAC_W + 9;
    localparam int unsigned A_W = FRAC_W + 11;
    localparam int unsigned Q_W = A_W - FRAC_W;

    logic [L_W-1:0] l_reg;
    logic [A_W-1:0] a_reg, b_reg;

    // modulo arithmetic, read back as two's complement
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            l_reg <= L_W'(s2l_pkg::L_SCALE) * L_W'(fy) - (L_W'(s2l_pkg::L_BIAS) << FRAC_W);
            a_reg <= A_W'(s2l_pkg::A_SCALE) * (A_W'(fx) - A_W'(fy));
            b_reg <= A_W'(s2l_pkg::B_SCALE) * (A_W'(fy) - A_W'(fz));
        end
    end

    logic [L_W-1:0]       l_int;
    logic [6:0]           l_sat;
    logic signed [7:0]    a_sat, b_sat;

    assign l_int = l_reg >> FRAC_W;
    always_comb begin
        if (l_reg[L_W-1]) begin
            l_sat = '0;
        end else if (l_int > L_W'(s2l_pkg::L_MAX)) begin
            l_sat = 7'(s2l_pkg::L_MAX);
        end else begin
            l_sat = 7'(l_int);
        end
    end

    function automatic logic [7:0] sat8(logic [A_W-1:0] v);
        logic           neg;
        logic [A_W-1:0] mag;
        logic [Q_W-1:0] q;
        logic [7:0]     r;
        neg = v[A_W-1];
        mag = neg ? (~v + A_W'(1)) : v;
        q   = Q_W'(mag >> FRAC_W);
        if (neg) begin
            r = (q > Q_W'(128)) ? 8'h80 : 8'(Q_W'(0) - q);
        end else begin
            r = (q > Q_W'(127)) ? 8'h7f : 8'(q);
        end
        return r;
    endfunction

    assign a_sat = $signed(sat8(a_reg));
    assign b_sat = $signed(sat8(b_reg));

    s2l_pkg::pixel_out_t pix_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            pix_reg.lightness <= l_sat;
            pix_reg.a_star    <= a_sat;
            pix_reg.b_star    <= b_sat;
        end
    end

    assign pix = pix_reg;

endmodule

`default_nettype wire

[rtl/s2l_chk.sv]
// port-level checks for the srgb to cielab pipeline, bound to the top level
`default_nettype none

module s2l_chk (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire s2l_pkg::pixel_in_t   s_data,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire s2l_pkg::pixel_out_t  m_data
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a waiting request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("waiting request changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // lightness saturates at 100
    a_l_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.lightness <= 7'd100)
        else $error("lightness out of range");

endmodule

bind srgb_to_cielab_pixel s2l_chk u_chk (.*);

`default_nettype wire

[sim/srgb_to_cielab_pixel_chk.sv]
// channel monitor and lab predictor for the srgb to cielab pixel block
`timescale 1ns / 100ps
`default_nettype none

module srgb_to_cielab_pixel_chk #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire s2l_pkg::pixel_in_t   s_data,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire s2l_pkg::pixel_out_t  m_data,
    output int                        fail_count,
    output int                        pending_count
);

    localparam int unsigned SEGS = 1 << s2l_pkg::SEG_BITS;
    localparam longint unsigned ONE = 64'd1 << 30;

    longint unsigned lin_tab[256];
    longint unsigned root_tab[SEGS + 1];
    s2l_pkg::pixel_out_t lab_queue[$];

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic longint unsigned q30_root(longint unsigned x, int n);
        longint unsigned lo, hi, mid, p;
        lo = 0;
        hi = ONE;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            p = mid;
            for (int i = 1; i < n; i++) p = q30_mul(p, mid);
            if (p <= x) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint unsigned q30_to_fix(longint unsigned v);
        return (v + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
    endfunction

    // lab companding: linear segment below the threshold, interpolated cube root above
    function automatic longint unsigned lab_curve(longint unsigned t);
        longint unsigned one_f, thr, off, idx, fr;
        int unsigned sh;
        one_f = 64'd1 << FRACTION_BITS;
        thr = ((64'd8856 << FRACTION_BITS) + 500000) / 1000000;
        off = ((64'd16 << FRACTION_BITS) + 58) / 116;
        sh = FRACTION_BITS - s2l_pkg::SEG_BITS;
        if (t > one_f) t = one_f;
        if (t <= thr) return (7787 * t + 500) / 1000 + off;
        idx = t >> sh;
        if (idx >= SEGS) return root_tab[SEGS];
        fr = t & ((64'd1 << sh) - 1);
        return root_tab[idx] + (((root_tab[idx + 1] - root_tab[idx]) * fr) >> sh);
    endfunction

    function automatic longint trunc_fix(longint v);
        if (v < 0) return -((-v) >>> FRACTION_BITS);
        return v >>> FRACTION_BITS;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic s2l_pkg::pixel_out_t predict_lab(s2l_pkg::pixel_in_t px);
        longint unsigned r, g, b, sx, sy, sz, fx, fy, fz;
        longint l, av, bv;
        s2l_pkg::pixel_out_t res;
        r = lin_tab[px.red];
        g = lin_tab[px.green];
        b = lin_tab[px.blue];
        sx = 4124 * r + 3576 * g + 1804 * b;
        sy = 2126 * r + 7152 * g + 722 * b;
        sz = 193 * r + 1192 * g + 9502 * b;
        fx = lab_curve((sx * 100 + 475228) / 950456);
        fy = lab_curve((sy + 5000) / 10000);
        fz = lab_curve((sz * 100 + 544377) / 1088754);
        l = 116 * longint'(fy) - longint'(64'd16 << FRACTION_BITS);
        av = 500 * (longint'(fx) - longint'(fy));
        bv = 200 * (longint'(fy) - longint'(fz));
        res.lightness = 7'(sat(trunc_fix(l), 0, 100));
        res.a_star = 8'(sat(trunc_fix(av), -128, 127));
        res.b_star = 8'(sat(trunc_fix(bv), -128, 127));
        return res;
    endfunction

    initial begin
        longint unsigned x, y, v;
        for (int c = 0; c < 256; c++) begin
            if (c * 100000 > 1031475) begin
                x = (((64'(c) * 1000 + 14025) << 30) + 134512) / 269025;
                y = q30_root(x, 5);
                v = q30_mul(q30_mul(x, x), q30_mul(y, y));
            end else begin
                v = (((64'(c) * 10) << 30) + 16473) / 32946;
            end
            lin_tab[c] = q30_to_fix(v);
        end
        for (int k = 0; k <= SEGS; k++)
            root_tab[k] = q30_to_fix(q30_root(64'(k) << (30 - s2l_pkg::SEG_BITS), 3));
    end

    always @(posedge aclk) begin
        s2l_pkg::pixel_out_t want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) lab_queue.push_back(predict_lab(s_data));
            if (m_valid && m_ready) begin
                if (lab_queue.size() == 0) begin
                    $error("result with nothing pending: %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = lab_queue.pop_front();
                    if (want.lightness !== m_data.lightness)
                        $error("lightness: expected %0d, got %0d",
                            want.lightness, m_data.lightness);
                    if (want.a_star !== m_data.a_star)
                        $error("a_star: expected %0d, got %0d", want.a_star, m_data.a_star);
                    if (want.b_star !== m_data.b_star)
                        $error("b_star: expected %0d, got %0d", want.b_star, m_data.b_star);
                    if (want !== m_data) fail_count <= fail_count + 1;
                end
            end
        end
        pending_count <= lab_queue.size();
    end
endmodule

`default_nettype wire

[sim/srgb_to_cielab_pixel_tb.sv]
// stimulus and verdict for the srgb to cielab pixel block
`timescale 1ns / 100ps
`default_nettype none

module srgb_to_cielab_pixel_tb;

    localparam int unsigned FRACTION_BITS = 16;
    localparam int          LATENCY       = 8 + (FRACTION_BITS + 4) / 4;
    localparam int          RANDOM_COUNT  = 1950;
    localparam longint      CYCLE_LIMIT   = 400000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    s2l_pkg::pixel_in_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    s2l_pkg::pixel_out_t m_data;
    int                  fail_count;
    int                  pending_count;

    // idle odds in percent, changed by phase
    int  send_idle_pct = 6;
    int  recv_idle_pct = 50;
    bit  hold_off = 1'b0;
    longint cycle_count = 0;

    always #5 aclk = ~aclk;

    srgb_to_cielab_pixel #(.FRACTION_BITS(FRACTION_BITS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    srgb_to_cielab_pixel_chk #(.FRACTION_BITS(FRACTION_BITS)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, or a forced long stall while hold_off is up
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver stall so the pipeline fills and backs up into s_ready
    initial begin
        int n;
        n = 0;
        wait (aresetn);
        repeat (300) @(posedge aclk);
        hold_off <= 1'b1;
        while (n < 200) begin
            @(posedge aclk);
            n++;
        end
        hold_off <= 1'b0;
    end

    // offer one request, with random idle cycles ahead of it
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{red: r, green: g, blue: b};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // mostly uniform bytes, with some near-black and near-white channels
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'($urandom_range(12));
            1: return 8'(255 - $urandom_range(8));
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        int wait_n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: black, white, primaries and secondaries, gamma knee, dark branch, mid tones
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd10, 8'd10, 8'd10);
        send_pixel(8'd11, 8'd11, 8'd11);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd5, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd5);
        send_pixel(8'd0, 8'd5, 8'd0);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd170, 8'd85, 8'd170);
        send_pixel(8'd85, 8'd170, 8'd85);

        for (int i = 0; i < RANDOM_COUNT; i++) begin
            if (i == RANDOM_COUNT / 3) begin
                send_idle_pct = 50;
                recv_idle_pct = 6;
            end else if (i == 2 * RANDOM_COUNT / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_pixel(pick_byte(), pick_byte(), pick_byte());
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        while (pending_count != 0) @(posedge aclk);
        wait_n = 0;
        while (wait_n < 2 * LATENCY) begin
            @(posedge aclk);
            wait_n++;
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

`default_nettype wire
